/* src/dq_pkg.sv */
// ----------------------------------------------------------------------------
// dq_pkg
// shared types and constants for the double-ended queue
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int DEPTH_DEF      = 1024;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int KIND_W     = 3;
    localparam int VALUE_W    = 32;
    localparam int COUNT_W    = 11;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 112;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_BACK  = 3'd0,
        KIND_PUSH_FRONT = 3'd1,
        KIND_POP_FRONT  = 3'd2,
        KIND_POP_BACK   = 3'd3,
        KIND_PEEK       = 3'd4
    } kind_t;

    typedef enum logic {
        ST_IDLE,
        ST_FETCH
    } state_t;

    typedef struct packed {
        logic               pop_valid;
        logic [VALUE_W-1:0] pop_value;
        logic               ends_valid;
        logic [VALUE_W-1:0] front_value;
        logic [VALUE_W-1:0] back_value;
        logic [COUNT_W-1:0] entry_count;
        logic               is_empty;
        logic               push_dropped;
    } result_t;

endpackage

/* src/double_ended_queue.sv */
// ----------------------------------------------------------------------------
// double_ended_queue
// bounded double-ended queue held in a ring store with cached end words
// ----------------------------------------------------------------------------
// result: registered from the input transfer; a pop that leaves at least
//   one entry first passes through the fetch state to refetch the new end
// throughput: one item per cycle for pushes and peeks while m_tready holds;
//   such pops block new input during the refetch through the single read port
// reset: pointers, count and sequencer cleared; store contents undefined,
//   no clearing pass, as only occupied entries are ever read
module double_ended_queue
    import dq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // value[31:0]
    input  logic [KIND_W-1:0]    s_tuser,   // kind[2:0]
    // result channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // pop_valid[0], pop_value[32:1], ends_valid[33], front_value[65:34],
    // back_value[97:66], entry_count[108:98], is_empty[109],
    // push_dropped[110], zero pad[111]
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int PW = $clog2(DEPTH);

    logic                          in_accept;
    logic                          busy;
    logic                          res_load;
    result_t                       res;
    logic [DATA_WIDTH+VALUE_W-1:0] value_ext;
    logic [DATA_WIDTH-1:0]         word;

    logic                          wr_en, rd_en;
    logic [PW-1:0]                 wr_addr, rd_addr;
    logic [DATA_WIDTH-1:0]         wr_data, rd_data;

    logic                          m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]          m_data_reg, m_data_next;

    // take a new transfer only when the sequencer is free and the result
    // register is empty or being emptied this cycle
    assign s_tready  = !busy && (!m_valid_reg || m_tready);
    assign in_accept = s_tvalid && s_tready;

    // keep only the low DATA_WIDTH bits of the pushed word
    assign value_ext = {{DATA_WIDTH{1'b0}}, s_tdata[VALUE_W-1:0]};
    assign word      = value_ext[DATA_WIDTH-1:0];

    dq_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .kind      (kind_t'(s_tuser)),
        .word      (word),
        .busy      (busy),
        .res_load  (res_load),
        .res       (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    dq_ram #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // result register: loads only when free or being drained
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (res_load) begin
            m_valid_next = 1'b1;
            m_data_next  = {1'b0, res.push_dropped, res.is_empty, res.entry_count,
                            res.back_value, res.front_value, res.ends_valid,
                            res.pop_value, res.pop_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // a result is only produced into a free or draining register
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        res_load |-> (!m_valid_reg || m_tready))
        else $error("result register overwritten before transfer");

    // every accepted transfer yields a result, directly or after the refetch
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |-> (res_load or (##1 res_load)))
        else $error("accepted item produced no result");

    // sequencer busy only right after an accepted transfer
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(busy) |-> $past(in_accept))
        else $error("refetch started without a transfer");

endmodule

/* src/dq_ram.sv */
// ----------------------------------------------------------------------------
// dq_ram
// entry store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module dq_ram
    import dq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int PW         = $clog2(DEPTH)
) (
    input  logic                  aclk,
    input  logic                  wr_en,
    input  logic [PW-1:0]         wr_addr,
    input  logic [DATA_WIDTH-1:0] wr_data,
    input  logic                  rd_en,
    input  logic [PW-1:0]         rd_addr,
    output logic [DATA_WIDTH-1:0] rd_data
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* src/dq_ctrl.sv */
// ----------------------------------------------------------------------------
// dq_ctrl
// ring pointers, occupancy, cached end words and the refetch sequencer
// ----------------------------------------------------------------------------
module dq_ctrl
    import dq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int PW         = $clog2(DEPTH),
    parameter int CW         = $clog2(DEPTH + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_accept,
    input  kind_t                 kind,
    input  logic [DATA_WIDTH-1:0] word,
    output logic                  busy,
    output logic                  res_load,
    output result_t               res,
    output logic                  wr_en,
    output logic [PW-1:0]         wr_addr,
    output logic [DATA_WIDTH-1:0] wr_data,
    output logic                  rd_en,
    output logic [PW-1:0]         rd_addr,
    input  logic [DATA_WIDTH-1:0] rd_data
);

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
        return (p == '0) ? PW'(DEPTH - 1) : p - PW'(1);
    endfunction

    state_t                state_reg, state_next;
    logic [PW-1:0]         head_reg, head_next;
    logic [PW-1:0]         tail_reg, tail_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [DATA_WIDTH-1:0] front_reg, front_next;
    logic [DATA_WIDTH-1:0] back_reg, back_next;
    logic [DATA_WIDTH-1:0] pend_reg, pend_next;
    logic                  fetch_front_reg, fetch_front_next;

    logic [PW-1:0]         head_inc, head_dec, tail_inc, tail_dec, tail_dec2;
    logic                  full, empty, pop_ok, dropped, ends;
    logic [DATA_WIDTH-1:0] popped;

    logic [DATA_WIDTH+VALUE_W-1:0] pop_ext, front_ext, back_ext;
    logic [CW+COUNT_W-1:0]         count_ext;

    assign head_inc  = ptr_inc(head_reg);
    assign head_dec  = ptr_dec(head_reg);
    assign tail_inc  = ptr_inc(tail_reg);
    assign tail_dec  = ptr_dec(tail_reg);
    assign tail_dec2 = ptr_dec(tail_dec);
    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);
    assign busy      = (state_reg == ST_FETCH);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        front_reg       <= front_next;
        back_reg        <= back_next;
        pend_reg        <= pend_next;
        fetch_front_reg <= fetch_front_next;
    end

    always_comb begin
        state_next       = state_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        count_next       = count_reg;
        front_next       = front_reg;
        back_next        = back_reg;
        pend_next        = pend_reg;
        fetch_front_next = fetch_front_reg;
        wr_en            = 1'b0;
        wr_addr          = tail_reg;
        wr_data          = word;
        rd_en            = 1'b0;
        rd_addr          = head_inc;
        res_load         = 1'b0;
        pop_ok           = 1'b0;
        popped           = '0;
        dropped          = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    case (kind)
                        KIND_PUSH_BACK: begin
                            if (full) begin
                                dropped = 1'b1;
                            end else begin
                                wr_en      = 1'b1;
                                wr_addr    = tail_reg;
                                tail_next  = tail_inc;
                                back_next  = word;
                                count_next = count_reg + CW'(1);
                                if (empty) begin
                                    front_next = word;
                                end
                            end
                        end
                        KIND_PUSH_FRONT: begin
                            if (full) begin
                                dropped = 1'b1;
                            end else begin
                                wr_en      = 1'b1;
                                wr_addr    = head_dec;
                                head_next  = head_dec;
                                front_next = word;
                                count_next = count_reg + CW'(1);
                                if (empty) begin
                                    back_next = word;
                                end
                            end
                        end
                        KIND_POP_FRONT: begin
                            if (!empty) begin
                                pop_ok     = 1'b1;
                                popped     = front_reg;
                                head_next  = head_inc;
                                count_next = count_reg - CW'(1);
                                // new front lives only in the store
                                if (count_reg > CW'(1)) begin
                                    rd_en            = 1'b1;
                                    rd_addr          = head_inc;
                                    fetch_front_next = 1'b1;
                                end
                            end
                        end
                        KIND_POP_BACK: begin
                            if (!empty) begin
                                pop_ok     = 1'b1;
                                popped     = back_reg;
                                tail_next  = tail_dec;
                                count_next = count_reg - CW'(1);
                                if (count_reg > CW'(1)) begin
                                    rd_en            = 1'b1;
                                    rd_addr          = tail_dec2;
                                    fetch_front_next = 1'b0;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (rd_en) begin
                        state_next = ST_FETCH;
                        pend_next  = popped;
                    end else begin
                        res_load = 1'b1;
                    end
                end
            end
            ST_FETCH: begin
                if (fetch_front_reg) begin
                    front_next = rd_data;
                end else begin
                    back_next = rd_data;
                end
                pop_ok     = 1'b1;
                popped     = pend_reg;
                res_load   = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign ends      = (count_next != '0);
    assign pop_ext   = {{VALUE_W{1'b0}}, popped};
    assign front_ext = {{VALUE_W{1'b0}}, ends ? front_next : {DATA_WIDTH{1'b0}}};
    assign back_ext  = {{VALUE_W{1'b0}}, ends ? back_next : {DATA_WIDTH{1'b0}}};
    assign count_ext = {{COUNT_W{1'b0}}, count_next};

    always_comb begin
        res.pop_valid    = pop_ok;
        res.pop_value    = pop_ext[VALUE_W-1:0];
        res.ends_valid   = ends;
        res.front_value  = front_ext[VALUE_W-1:0];
        res.back_value   = back_ext[VALUE_W-1:0];
        res.entry_count  = count_ext[COUNT_W-1:0];
        res.is_empty     = !ends;
        res.push_dropped = dropped;
    end

    // refetch state only follows a cycle that issued a store read
    a_fetch_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FETCH |-> $past(rd_en))
        else $error("fetch state without a preceding store read");

    // a store read and a store write never share a cycle
    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(wr_en && rd_en))
        else $error("store read and write in the same cycle");

    // an empty ring has coinciding pointers
    a_empty_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == '0 |-> head_reg == tail_reg)
        else $error("empty ring with differing pointers");

    // no new transfer taken while a refetch is outstanding
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FETCH |-> !in_accept)
        else $error("transfer accepted during refetch");

endmodule
